FILE: hdl/assert_macros.svh
// Assertion helpers for the checker file blr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("clocked assertion failed");

// Signal must stay low while reset is asserted.
`define ASSERT_IN_RESET(lbl, clk, rst_n, sig) \
    lbl: assert property (@(posedge clk) !rst_n |-> !(sig)) \
        else $error("signal active during reset");

`endif

FILE: hdl/blr_pkg.sv
package blr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int POS_BITS    = COORD_BITS + 1;
    localparam int DIFF_BITS   = COORD_BITS + 2;
    localparam int TR_BITS     = COORD_BITS + 2;
    localparam int TRR_BITS    = COORD_BITS + 3;
    localparam int DEC_BITS    = COORD_BITS + 4;
    localparam int INDEX_BITS  = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [1:0] CASE_SHALLOW_UP   = 2'd0;
    localparam logic [1:0] CASE_SHALLOW_DOWN = 2'd1;
    localparam logic [1:0] CASE_STEEP_UP     = 2'd2;
    localparam logic [1:0] CASE_STEEP_DOWN   = 2'd3;

    typedef struct packed {
        logic                         command;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic [INDEX_BITS-1:0]        pixel_index;
        logic                         last_pixel;
    } out_item_t;

    typedef struct packed {
        logic                       command;
        logic [1:0]                 fcase;
        logic signed [POS_BITS-1:0] major_start;
        logic signed [POS_BITS-1:0] minor_start;
        logic signed [POS_BITS-1:0] major_stop;
        logic signed [POS_BITS-1:0] minor_stop;
    } queue_entry_t;

endpackage

FILE: hdl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer. A load item (command 0) takes two endpoints and
// starts a line, replacing any line in progress; it gives no result. Each step
// item (command 1) gives the next pixel of the line with its index and a last
// flag, and returns the block to idle after the last pixel; a step while idle
// gives nothing. Items enter at one per clock while the queue has room: the
// front end folds the line into one of four slope cases, a two-entry queue
// decouples it from the walker, and the single decision-variable update of
// the walker sets the rate of one pixel per clock unless the output stalls.
// A result is registered at the clock edge at which its step item leaves the
// queue, so it passes through a queue slot and then the output register.
module bresenham_line_rasterizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  blr_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output blr_pkg::out_item_t out_data
);
    import blr_pkg::*;

    queue_entry_t front_entry;
    queue_entry_t q_entry;
    logic         q_valid;
    logic         q_ready;

    blr_front u_front (
        .in_data (in_data),
        .entry   (front_entry)
    );

    blr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_entry (front_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_entry  (q_entry)
    );

    blr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_entry   (q_entry),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: hdl/blr_front.sv
module blr_front (
    input  blr_pkg::in_item_t     in_data,
    output blr_pkg::queue_entry_t entry
);
    import blr_pkg::*;

    logic                         swap;
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    logic signed [DIFF_BITS-1:0]  dx, dy, ndx;
    logic signed [POS_BITS-1:0]   ax_w, ay_w, bx_w, by_w;

    always_comb
    begin
        swap = in_data.end_x < in_data.start_x;
        ax   = swap ? in_data.end_x   : in_data.start_x;
        ay   = swap ? in_data.end_y   : in_data.start_y;
        bx   = swap ? in_data.start_x : in_data.end_x;
        by   = swap ? in_data.start_y : in_data.end_y;
        dx   = DIFF_BITS'(bx) - DIFF_BITS'(ax);
        dy   = DIFF_BITS'(by) - DIFF_BITS'(ay);
        ndx  = -dx;
        ax_w = POS_BITS'(ax);
        ay_w = POS_BITS'(ay);
        bx_w = POS_BITS'(bx);
        by_w = POS_BITS'(by);

        entry.command = in_data.command;
        if (dy >= 0 && dy <= dx)
        begin
            entry.fcase       = CASE_SHALLOW_UP;
            entry.major_start = ax_w;
            entry.minor_start = ay_w;
            entry.major_stop  = bx_w;
            entry.minor_stop  = by_w;
        end
        else if (dy < 0 && dy >= ndx)
        begin
            entry.fcase       = CASE_SHALLOW_DOWN;
            entry.major_start = ax_w;
            entry.minor_start = -ay_w;
            entry.major_stop  = bx_w;
            entry.minor_stop  = -by_w;
        end
        else if (dy > dx)
        begin
            entry.fcase       = CASE_STEEP_UP;
            entry.major_start = ay_w;
            entry.minor_start = ax_w;
            entry.major_stop  = by_w;
            entry.minor_stop  = bx_w;
        end
        else
        begin
            entry.fcase       = CASE_STEEP_DOWN;
            entry.major_start = by_w;
            entry.minor_start = -bx_w;
            entry.major_stop  = ay_w;
            entry.minor_stop  = -ax_w;
        end
    end

endmodule

FILE: hdl/blr_queue.sv
module blr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  blr_pkg::queue_entry_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output blr_pkg::queue_entry_t pop_entry
);
    import blr_pkg::*;

    queue_entry_t         slot_reg [QUEUE_DEPTH];
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic                 push, pop;

    assign push_ready = count_reg != QCNT_BITS'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hdl/blr_back.sv
module blr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  blr_pkg::queue_entry_t q_entry,
    output logic                  out_valid,
    input  logic                  out_ready,
    output blr_pkg::out_item_t    out_data
);
    import blr_pkg::*;

    logic                        busy_reg, busy_next;
    logic [1:0]                  case_reg, case_next;
    logic signed [POS_BITS-1:0]  major_reg, major_next;
    logic signed [POS_BITS-1:0]  minor_reg, minor_next;
    logic signed [POS_BITS-1:0]  end_reg, end_next;
    logic signed [DEC_BITS-1:0]  dec_reg, dec_next;
    logic signed [TR_BITS-1:0]   tr_reg, tr_next;
    logic signed [TRR_BITS-1:0]  trr_reg, trr_next;
    logic [INDEX_BITS-1:0]       count_reg, count_next;
    logic                        out_valid_reg, out_valid_next;
    out_item_t                   out_data_reg, out_data_next;

    logic                        pop, emit, last;
    logic signed [DEC_BITS-1:0]  run, rise, rise2;
    logic signed [POS_BITS-1:0]  neg_minor;

    assign q_ready   = !out_valid_reg || out_ready;
    assign pop       = q_valid && q_ready;
    assign emit      = pop && q_entry.command == CMD_STEP && busy_reg;
    assign last      = major_reg >= end_reg;
    assign neg_minor = -minor_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        run   = DEC_BITS'(q_entry.major_stop) - DEC_BITS'(q_entry.major_start);
        rise  = DEC_BITS'(q_entry.minor_stop) - DEC_BITS'(q_entry.minor_start);
        rise2 = rise + rise;

        busy_next  = busy_reg;
        case_next  = case_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        end_next   = end_reg;
        dec_next   = dec_reg;
        tr_next    = tr_reg;
        trr_next   = trr_reg;
        count_next = count_reg;

        out_data_next = out_data_reg;
        out_data_next.pixel_index = count_reg;
        out_data_next.last_pixel  = last;
        case (case_reg)
            CASE_SHALLOW_UP:
            begin
                out_data_next.pixel_x = COORD_BITS'(major_reg);
                out_data_next.pixel_y = COORD_BITS'(minor_reg);
            end
            CASE_SHALLOW_DOWN:
            begin
                out_data_next.pixel_x = COORD_BITS'(major_reg);
                out_data_next.pixel_y = COORD_BITS'(neg_minor);
            end
            CASE_STEEP_UP:
            begin
                out_data_next.pixel_x = COORD_BITS'(minor_reg);
                out_data_next.pixel_y = COORD_BITS'(major_reg);
            end
            default:
            begin
                out_data_next.pixel_x = COORD_BITS'(neg_minor);
                out_data_next.pixel_y = COORD_BITS'(major_reg);
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        if (pop && q_entry.command == CMD_LOAD)
        begin
            busy_next  = 1'b1;
            case_next  = q_entry.fcase;
            major_next = q_entry.major_start;
            minor_next = q_entry.minor_start;
            end_next   = q_entry.major_stop;
            tr_next    = TR_BITS'(rise2);
            trr_next   = TRR_BITS'(rise2 - run - run);
            dec_next   = rise2 - run;
            count_next = '0;
        end
        else if (emit)
        begin
            if (dec_reg <= 0)
            begin
                dec_next = dec_reg + DEC_BITS'(tr_reg);
            end
            else
            begin
                dec_next   = dec_reg + DEC_BITS'(trr_reg);
                minor_next = minor_reg + POS_BITS'(1);
            end
            major_next = major_reg + POS_BITS'(1);
            count_next = count_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            case_reg      <= CASE_SHALLOW_UP;
            major_reg     <= '0;
            minor_reg     <= '0;
            end_reg       <= '0;
            dec_reg       <= '0;
            tr_reg        <= '0;
            trr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            case_reg      <= case_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            end_reg       <= end_next;
            dec_reg       <= dec_next;
            tr_reg        <= tr_next;
            trr_reg       <= trr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: hdl/blr_checker.sv
`include "assert_macros.svh"

module blr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input blr_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input blr_pkg::out_item_t out_data
);
    import blr_pkg::*;

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))

    // the queue only fills up behind a result that is waiting
    `ASSERT_CLK(a_full_needs_stall, clk, rst_n, !in_ready |-> out_valid)

    // pixel index restarts only at the first pixel of a line that came in after a load
    `ASSERT_CLK(a_index_valid, clk, rst_n, out_valid && out_ready && !out_data.last_pixel |=> !out_valid || out_data.pixel_index != '0 || $past(in_valid && in_ready && in_data.command == CMD_LOAD) || $past(in_valid && in_ready, 2) || $past(in_valid && in_ready, 3))

    `ASSERT_IN_RESET(a_reset_quiet, clk, rst_n, out_valid)

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);
